>>> hdl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants of the space-vector PWM core with dead-time
// compensation.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DATA_W       = 16;
    localparam int SECTOR_W     = 3;
    localparam int AMOUNT_W     = 12;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 12;
    localparam int PROD_W       = 31;
    localparam int TIME_W       = 34;

    localparam logic signed [DATA_W-1:0] SQRT3_HALF_Q15 = 16'sd28378;
    localparam logic signed [DATA_W-1:0] DUTY_LIMIT_Q15 = 16'sd31457;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_COMP_ENABLE = 1'b0;
    localparam cfg_index_t CFG_COMP_AMOUNT = 1'b1;

    typedef struct packed {
        logic pos;
        logic neg;
    } cur_sign_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] v_alpha;
        logic signed [DATA_W-1:0] v_beta;
        logic signed [DATA_W-1:0] cur_a;
        logic signed [DATA_W-1:0] cur_b;
        logic signed [DATA_W-1:0] cur_c;
    } ref_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] ka;
        logic signed [DATA_W-1:0] ub;
        cur_sign_t                sgn_a;
        cur_sign_t                sgn_b;
        cur_sign_t                sgn_c;
    } prod_item_t;

    typedef struct packed {
        logic                comp_enable;
        logic [AMOUNT_W-1:0] comp_amount;
    } comp_cfg_t;

    function automatic cur_sign_t cur_sign(input logic [DATA_W-1:0] v);
        cur_sign_t s;
        s.neg = v[SAMPLE_WIDTH-1];
        s.pos = !v[SAMPLE_WIDTH-1] && (v[SAMPLE_WIDTH-1:0] != '0);
        return s;
    endfunction

endpackage

>>> hdl/space_vector_pwm_with_deadtime_comp_core.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_with_deadtime_comp_core
// Space-vector PWM generator: sector and three phase duties from an alpha/beta
// voltage reference, with dead-time compensation by phase current sign.
// ----------------------------------------------------------------------------
// Every accepted beat passes through the input register, the product stage
// and the output register before it shows up as a valid result beat; a new
// beat is taken every cycle while the result side keeps up. The path is an
// input register, a stage holding the alpha * sqrt(3)/2 product and the
// current signs, and the output register holding duties and sector. comp_enable
// and comp_amount are read live by the last stage, so write them while idle.
module space_vector_pwm_with_deadtime_comp_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  svpwm_pkg::cfg_index_t                 cfg_index,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [svpwm_pkg::DATA_W-1:0]   s_v_alpha,
    input  logic signed [svpwm_pkg::DATA_W-1:0]   s_v_beta,
    input  logic signed [svpwm_pkg::DATA_W-1:0]   s_cur_a,
    input  logic signed [svpwm_pkg::DATA_W-1:0]   s_cur_b,
    input  logic signed [svpwm_pkg::DATA_W-1:0]   s_cur_c,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [svpwm_pkg::DATA_W-1:0]   m_duty_a,
    output logic signed [svpwm_pkg::DATA_W-1:0]   m_duty_b,
    output logic signed [svpwm_pkg::DATA_W-1:0]   m_duty_c,
    output logic [svpwm_pkg::SECTOR_W-1:0]        m_sector
);

    svpwm_pkg::comp_cfg_t  cfg_reg;
    svpwm_pkg::comp_cfg_t  cfg_next;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    svpwm_pkg::ref_item_t  in_item_reg;
    logic                  mult_ready;
    logic                  prod_valid;
    logic                  prod_ready;
    svpwm_pkg::prod_item_t prod_item;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                svpwm_pkg::CFG_COMP_ENABLE: cfg_next.comp_enable = cfg_wdata[0];
                svpwm_pkg::CFG_COMP_AMOUNT:
                    cfg_next.comp_amount = cfg_wdata[svpwm_pkg::AMOUNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready       = !in_valid_reg || mult_ready;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.v_alpha <= s_v_alpha;
            in_item_reg.v_beta  <= s_v_beta;
            in_item_reg.cur_a   <= s_cur_a;
            in_item_reg.cur_b   <= s_cur_b;
            in_item_reg.cur_c   <= s_cur_c;
        end
    end

    svpwm_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (mult_ready),
        .in_item   (in_item_reg),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_item  (prod_item)
    );

    svpwm_duty u_duty (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (prod_valid),
        .in_ready   (prod_ready),
        .in_item    (prod_item),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_duty_a (m_duty_a),
        .out_duty_b (m_duty_b),
        .out_duty_c (m_duty_c),
        .out_sector (m_sector)
    );

endmodule

>>> hdl/svpwm_mult.sv
// ----------------------------------------------------------------------------
// svpwm_mult
// Product stage: scales alpha by sqrt(3)/2 and takes the current signs.
// ----------------------------------------------------------------------------
module svpwm_mult (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  svpwm_pkg::ref_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output svpwm_pkg::prod_item_t  out_item
);

    logic                  valid_reg;
    logic                  valid_next;
    svpwm_pkg::prod_item_t item_reg;
    svpwm_pkg::prod_item_t item_next;
    logic signed [2*svpwm_pkg::DATA_W-1:0] prod;

    assign in_ready = !valid_reg || out_ready;
    assign prod     = in_item.v_alpha * svpwm_pkg::SQRT3_HALF_Q15;

    always_comb begin
        item_next.ka    = prod[svpwm_pkg::PROD_W-1:0];
        item_next.ub    = in_item.v_beta;
        item_next.sgn_a = svpwm_pkg::cur_sign(in_item.cur_a);
        item_next.sgn_b = svpwm_pkg::cur_sign(in_item.cur_b);
        item_next.sgn_c = svpwm_pkg::cur_sign(in_item.cur_c);
        valid_next      = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hdl/svpwm_duty.sv
// ----------------------------------------------------------------------------
// svpwm_duty
// Result stage: sector, X/Y/Z times, duty rounding and clamping, dead-time
// compensation and saturation into the output register.
// ----------------------------------------------------------------------------
module svpwm_duty (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  svpwm_pkg::comp_cfg_t                  cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  svpwm_pkg::prod_item_t                 in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [svpwm_pkg::DATA_W-1:0]   out_duty_a,
    output logic signed [svpwm_pkg::DATA_W-1:0]   out_duty_b,
    output logic signed [svpwm_pkg::DATA_W-1:0]   out_duty_c,
    output logic [svpwm_pkg::SECTOR_W-1:0]        out_sector
);

    localparam int TW = svpwm_pkg::TIME_W;
    localparam int DW = svpwm_pkg::DATA_W;

    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_NONE = 3'd0;
    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_1    = 3'd1;
    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_2    = 3'd2;
    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_3    = 3'd3;
    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_4    = 3'd4;
    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_5    = 3'd5;
    localparam logic [svpwm_pkg::SECTOR_W-1:0] SECTOR_6    = 3'd6;

    function automatic logic signed [DW-1:0] to_duty(input logic signed [TW-1:0] v);
        logic signed [TW-1:0]    b;
        logic signed [TW-16:0]   r;
        logic signed [DW-1:0]    d;
        b = v + TW'(16384);
        r = b[TW-1:15];
        if (r >= (TW-15)'(svpwm_pkg::DUTY_LIMIT_Q15)) begin
            d = svpwm_pkg::DUTY_LIMIT_Q15;
        end else if (r <= -(TW-15)'(svpwm_pkg::DUTY_LIMIT_Q15)) begin
            d = -svpwm_pkg::DUTY_LIMIT_Q15;
        end else begin
            d = r[DW-1:0];
        end
        return d;
    endfunction

    function automatic logic signed [DW-1:0] compensate(
        input logic signed [DW-1:0] d,
        input svpwm_pkg::cur_sign_t s,
        input svpwm_pkg::comp_cfg_t c
    );
        logic signed [DW:0] amt;
        logic signed [DW:0] r;
        logic signed [DW-1:0] q;
        amt = {{(DW+1-svpwm_pkg::AMOUNT_W){1'b0}}, c.comp_amount};
        r   = {d[DW-1], d};
        if (c.comp_enable && s.pos) begin
            r = r + amt;
        end else if (c.comp_enable && s.neg) begin
            r = r - amt;
        end
        if (!r[DW] && r[DW-1]) begin
            q = {1'b0, {(DW-1){1'b1}}};
        end else if (r[DW] && !r[DW-1]) begin
            q = {1'b1, {(DW-1){1'b0}}};
        end else begin
            q = r[DW-1:0];
        end
        return q;
    endfunction

    logic                                 valid_reg;
    logic                                 valid_next;
    logic signed [DW-1:0]                 duty_a_reg, duty_b_reg, duty_c_reg;
    logic signed [DW-1:0]                 duty_a_next, duty_b_next, duty_c_next;
    logic [svpwm_pkg::SECTOR_W-1:0]       sector_reg;
    logic [svpwm_pkg::SECTOR_W-1:0]       sector_next;
    logic [svpwm_pkg::SECTOR_W-1:0]       sec_raw;
    logic signed [TW-1:0] hb, x, ka, y, z;
    logic signed [TW-1:0] t1, t2, first, second, third;
    logic signed [TW-1:0] da, db, dc;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        hb = {{(TW-DW-14){in_item.ub[DW-1]}}, in_item.ub, 14'b0};
        x  = {{(TW-DW-15){in_item.ub[DW-1]}}, in_item.ub, 15'b0};
        ka = {{(TW-svpwm_pkg::PROD_W){in_item.ka[svpwm_pkg::PROD_W-1]}}, in_item.ka};
        y  = hb + ka;
        z  = hb - ka;
        sec_raw = {y[TW-1], z[TW-1], !in_item.ub[DW-1] && (in_item.ub != '0)};

        t1 = '0;
        t2 = '0;
        sector_next = sec_raw;
        case (sec_raw)
            SECTOR_1: begin t1 = z;  t2 = y;  end
            SECTOR_2: begin t1 = y;  t2 = -x; end
            SECTOR_3: begin t1 = -z; t2 = x;  end
            SECTOR_4: begin t1 = -x; t2 = z;  end
            SECTOR_5: begin t1 = x;  t2 = -y; end
            SECTOR_6: begin t1 = -y; t2 = -z; end
            default:  begin sector_next = SECTOR_NONE; end
        endcase

        first  = -(t1 + t2);
        second = t1 - t2;
        third  = t1 + t2;

        case (sector_next)
            SECTOR_1: begin db = first;  da = second; dc = third; end
            SECTOR_2: begin da = first;  dc = second; db = third; end
            SECTOR_3: begin da = first;  db = second; dc = third; end
            SECTOR_4: begin dc = first;  db = second; da = third; end
            SECTOR_5: begin db = first;  dc = second; da = third; end
            SECTOR_6: begin dc = first;  da = second; db = third; end
            default:  begin da = '0;     db = '0;     dc = '0;    end
        endcase

        duty_a_next = compensate(to_duty(da), in_item.sgn_a, cfg);
        duty_b_next = compensate(to_duty(db), in_item.sgn_b, cfg);
        duty_c_next = compensate(to_duty(dc), in_item.sgn_c, cfg);
        valid_next  = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            duty_c_reg <= duty_c_next;
            sector_reg <= sector_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_duty_a = duty_a_reg;
    assign out_duty_b = duty_b_reg;
    assign out_duty_c = duty_c_reg;
    assign out_sector = sector_reg;

endmodule

>>> hdl/svpwm_checker.sv
// ----------------------------------------------------------------------------
// svpwm_props
// Port-level checks of the space-vector PWM core, bound to the top level.
// ----------------------------------------------------------------------------
module svpwm_props (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [svpwm_pkg::DATA_W-1:0]   m_duty_a,
    input logic signed [svpwm_pkg::DATA_W-1:0]   m_duty_b,
    input logic signed [svpwm_pkg::DATA_W-1:0]   m_duty_c,
    input logic [svpwm_pkg::SECTOR_W-1:0]        m_sector
);

    localparam logic signed [svpwm_pkg::DATA_W-1:0] ORIGIN_BOUND = 16'sd4095;

    // no result beat right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sector != 3'd7)
        else $error("sector code out of range");

    // origin duty is only the compensation offset
    a_origin_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sector == 3'd0 |->
            m_duty_a <= ORIGIN_BOUND && m_duty_a >= -ORIGIN_BOUND &&
            m_duty_b <= ORIGIN_BOUND && m_duty_b >= -ORIGIN_BOUND &&
            m_duty_c <= ORIGIN_BOUND && m_duty_c >= -ORIGIN_BOUND)
        else $error("origin duty beyond compensation range");

    // an accepted beat gives a valid result beat when the result side does not stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result beat missing after accepted beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duty_a) && $stable(m_sector))
        else $error("stalled result beat changed");

endmodule

bind space_vector_pwm_with_deadtime_comp_core svpwm_props u_svpwm_props (.*);

>>> tb/svpwm_checker.sv
// ----------------------------------------------------------------------------
// svpwm_checker
// Watches the configuration port and both channels of the space-vector PWM
// core. Each input beat is turned into its expected duties and sector, which
// are queued and compared field by field with the result beats in order.
// ----------------------------------------------------------------------------
module svpwm_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  svpwm_pkg::cfg_index_t               cfg_index,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [svpwm_pkg::DATA_W-1:0] s_v_alpha,
    input  logic signed [svpwm_pkg::DATA_W-1:0] s_v_beta,
    input  logic signed [svpwm_pkg::DATA_W-1:0] s_cur_a,
    input  logic signed [svpwm_pkg::DATA_W-1:0] s_cur_b,
    input  logic signed [svpwm_pkg::DATA_W-1:0] s_cur_c,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [svpwm_pkg::DATA_W-1:0] m_duty_a,
    input  logic signed [svpwm_pkg::DATA_W-1:0] m_duty_b,
    input  logic signed [svpwm_pkg::DATA_W-1:0] m_duty_c,
    input  logic [svpwm_pkg::SECTOR_W-1:0]      m_sector,
    output int                                  fail_count,
    output int                                  pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    import svpwm_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] duty_a;
        logic signed [DATA_W-1:0] duty_b;
        logic signed [DATA_W-1:0] duty_c;
        logic [SECTOR_W-1:0]      sector;
    } duty_beat_t;

    logic                comp_on;
    logic [AMOUNT_W-1:0] comp_mag;
    duty_beat_t          expected_duties[$];
    int                  mismatches = 0;

    assign fail_count = mismatches;

    // q2.30 to q1.15, nearest with ties up, then the 0.96 clamp
    function automatic longint round_clamp(input longint q30);
        longint r;
        longint lim;
        lim = longint'(DUTY_LIMIT_Q15);
        r = (q30 + 64'sd16384) >>> 15;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] comp_duty(input longint d,
                                                           input logic [DATA_W-1:0] cur);
        longint r;
        r = d;
        if (comp_on) begin
            if (cur[SAMPLE_WIDTH-1]) r = r - longint'(comp_mag);
            else if (cur[SAMPLE_WIDTH-1:0] != '0) r = r + longint'(comp_mag);
        end
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
        return r[DATA_W-1:0];
    endfunction

    function automatic duty_beat_t predict_duties(input ref_item_t it);
        duty_beat_t          d;
        longint              ua, ub, ka, hb, x, y, z;
        longint              t1, t2, lead, mid, tail, pa, pb, pc;
        logic [SECTOR_W-1:0] sec;
        ua = longint'($signed(it.v_alpha));
        ub = longint'($signed(it.v_beta));
        ka = ua * longint'(SQRT3_HALF_Q15);
        hb = ub * 64'sd16384;
        x  = ub * 64'sd32768;
        y  = hb + ka;
        z  = hb - ka;
        sec = '0;
        if (x > 0) sec[0] = 1'b1;
        if (ka - hb > 0) sec[1] = 1'b1;
        if (-hb - ka > 0) sec[2] = 1'b1;
        t1 = 0;
        t2 = 0;
        case (sec)
            3'd1: begin t1 = z;  t2 = y;  end
            3'd2: begin t1 = y;  t2 = -x; end
            3'd3: begin t1 = -z; t2 = x;  end
            3'd4: begin t1 = -x; t2 = z;  end
            3'd5: begin t1 = x;  t2 = -y; end
            3'd6: begin t1 = -y; t2 = -z; end
            default: sec = '0;
        endcase
        lead = -(t1 + t2);
        mid  = t1 - t2;
        tail = t1 + t2;
        case (sec)
            3'd1: begin pb = lead; pa = mid; pc = tail; end
            3'd2: begin pa = lead; pc = mid; pb = tail; end
            3'd3: begin pa = lead; pb = mid; pc = tail; end
            3'd4: begin pc = lead; pb = mid; pa = tail; end
            3'd5: begin pb = lead; pc = mid; pa = tail; end
            3'd6: begin pc = lead; pa = mid; pb = tail; end
            default: begin pa = 0; pb = 0; pc = 0; end
        endcase
        d.duty_a = comp_duty(round_clamp(pa), it.cur_a);
        d.duty_b = comp_duty(round_clamp(pb), it.cur_b);
        d.duty_c = comp_duty(round_clamp(pc), it.cur_c);
        d.sector = sec;
        return d;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        duty_beat_t want;
        ref_item_t  item;
        if (!aresetn) begin
            comp_on  = 1'b0;
            comp_mag = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COMP_ENABLE: comp_on = cfg_wdata[0];
                    CFG_COMP_AMOUNT: comp_mag = cfg_wdata[AMOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_duties.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, actual %0d %0d %0d sector %0d",
                             $time, m_duty_a, m_duty_b, m_duty_c, m_sector);
                end else begin
                    want = expected_duties.pop_front();
                    check_field("duty_a", want.duty_a, m_duty_a);
                    check_field("duty_b", want.duty_b, m_duty_b);
                    check_field("duty_c", want.duty_c, m_duty_c);
                    check_field("sector", want.sector, m_sector);
                end
            end
            if (s_valid && s_ready) begin
                item.v_alpha = s_v_alpha;
                item.v_beta  = s_v_beta;
                item.cur_a   = s_cur_a;
                item.cur_b   = s_cur_b;
                item.cur_c   = s_cur_c;
                expected_duties.push_back(predict_duties(item));
            end
        end
        pending_beats <= expected_duties.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the space-vector PWM core: corner references and currents,
// then random phases under several compensation settings, with random gaps
// and stalls on both channels, long result-side hold-offs and a watchdog.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import svpwm_pkg::*;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 118;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam int BUSY_IDLE_PCT = 19;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_v_alpha;
    logic signed [DATA_W-1:0] s_v_beta;
    logic signed [DATA_W-1:0] s_cur_a;
    logic signed [DATA_W-1:0] s_cur_b;
    logic signed [DATA_W-1:0] s_cur_c;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_duty_a;
    logic signed [DATA_W-1:0] m_duty_b;
    logic signed [DATA_W-1:0] m_duty_c;
    logic [SECTOR_W-1:0]      m_sector;
    int                       fail_count;
    int                       pending_beats;
    int                       idle_pct;
    int                       hold_requests;

    space_vector_pwm_with_deadtime_comp_core dut (.*);

    svpwm_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [DATA_W-1:0] pick_voltage();
        int mag;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return DATA_W'($urandom);
            5, 6: return DATA_W'(int'($urandom_range(2000)) - 1000);
            7: begin
                case ($urandom_range(3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh8001;
                    default: return '0;
                endcase
            end
            default: begin
                mag = $urandom_range(32767, 20000);
                if ($urandom_range(1)) return DATA_W'(-mag);
                return DATA_W'(mag);
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_current();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'sd1;
            2: return -16'sd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic signed [DATA_W-1:0] va,
                             input logic signed [DATA_W-1:0] vb,
                             input logic signed [DATA_W-1:0] ca,
                             input logic signed [DATA_W-1:0] cb,
                             input logic signed [DATA_W-1:0] cc);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_v_alpha <= va;
        s_v_beta  <= vb;
        s_cur_a   <= ca;
        s_cur_b   <= cb;
        s_cur_c   <= cc;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // enable word carries random upper bits, only bit 0 counts
    task automatic write_config(input logic enable, input logic [AMOUNT_W-1:0] amount);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COMP_ENABLE;
        cfg_wdata <= {(CFG_DATA_W-1)'($urandom), enable};
        @(posedge aclk);
        cfg_index <= CFG_COMP_AMOUNT;
        cfg_wdata <= amount;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall = 0;
            else stall++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_COMP_ENABLE;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_v_alpha     <= '0;
        s_v_beta      <= '0;
        s_cur_a       <= '0;
        s_cur_b       <= '0;
        s_cur_c       <= '0;
        idle_pct      <= BUSY_IDLE_PCT;
        hold_requests <= 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // settings straight out of reset
        repeat (4) send_beat(pick_voltage(), pick_voltage(), pick_current(), pick_current(),
                             pick_current());
        drain_results();

        // corners with the widest compensation so the sums saturate
        write_config(1'b1, 12'd4095);
        send_beat(0, 0, 100, -100, 0);
        send_beat(32767, 0, 1, -1, 0);
        send_beat(-32768, 0, 32767, -32768, 1);
        send_beat(0, 32767, -1, 0, 32767);
        send_beat(0, -32768, 0, 1, -32768);
        send_beat(32767, 32767, -32768, -32768, -32768);
        send_beat(-32768, -32768, 32767, 32767, 32767);
        send_beat(32767, -32768, 1, 1, 1);
        send_beat(-32768, 32767, -1, -1, -1);
        send_beat(14189, 8192, 500, -500, 0);
        send_beat(0, 16384, -500, 0, 500);
        send_beat(-14189, 8192, 0, 500, -500);
        send_beat(-14189, -8192, 500, 500, -500);
        send_beat(0, -16384, -500, -500, 500);
        send_beat(14189, -8192, 500, -500, 500);
        send_beat(8192, 14189, 1, 1, -1);
        send_beat(-8192, 14189, -1, 1, 1);
        send_beat(1, 0, 1, 0, -1);
        send_beat(-1, 0, -1, 0, 1);
        send_beat(0, 1, 0, 0, 0);
        send_beat(0, -1, 7, -7, 0);
        send_beat(1, 1, -32768, 32767, 0);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: write_config(1'b1, 12'd3277);
                1: write_config(1'b0, 12'd4095);
                2: write_config(1'b1, 12'd0);
                3: write_config(1'b1, 12'd1);
                4: write_config(1'b1, 12'($urandom_range(4095)));
                5: write_config(1'b0, 12'($urandom_range(4095)));
                6: write_config(1'b1, 12'd4095);
                default: write_config(1'b1, 12'($urandom_range(3277)));
            endcase
            idle_pct <= (p == 2) ? 0 : BUSY_IDLE_PCT;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ((p == 3 || p == 6) && n == 40) hold_requests <= hold_requests + 1;
                send_beat(pick_voltage(), pick_voltage(), pick_current(), pick_current(),
                          pick_current());
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> space_vector_pwm_with_deadtime_comp_core.f
hdl/svpwm_pkg.sv
hdl/svpwm_mult.sv
hdl/svpwm_duty.sv
hdl/space_vector_pwm_with_deadtime_comp_core.sv
hdl/svpwm_checker.sv
tb/svpwm_checker.sv
tb/tb_top.sv
